/* rtl/kiwdg_pkg.sv */
// Shared types and constants of the keyed independent watchdog.
// Used by the channel interfaces and by the top level; no dependencies.
`timescale 1ns / 1ps

package kiwdg_pkg;

  // fixed field widths
  localparam int unsigned OpcodeW = 2;
  localparam int unsigned AddrW = 2;
  localparam int unsigned DataW = 16;
  localparam int unsigned ReadW = 12;

  // parameter defaults
  localparam int unsigned CounterBitsDefault = 12;
  localparam int unsigned MaxExponentDefault = 6;
  localparam int unsigned BaseDivideDefault = 4;

  // reset value of the reload and counter registers, cut to the counter width
  localparam int unsigned ResetReload = 4095;

  // key register codes
  localparam logic [DataW-1:0] KeyRefresh = 16'hAAAA;
  localparam logic [DataW-1:0] KeyStart = 16'hCCCC;
  localparam logic [DataW-1:0] KeyUnlock = 16'h5555;

  typedef enum logic [OpcodeW-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  typedef enum logic [AddrW-1:0] {
    ADDR_KEY     = 2'd0,
    ADDR_PRESCAL = 2'd1,
    ADDR_RELOAD  = 2'd2,
    ADDR_COUNTER = 2'd3
  } reg_addr_e;

  typedef struct packed {
    logic [ReadW-1:0] read_data;
    logic             timeout_pulse;
    logic             is_running;
  } out_item_t;

endpackage

/* rtl/kiwdg_if.sv */
// Valid/ready channel interfaces of the keyed independent watchdog.
// Depends on kiwdg_pkg for the field widths.
`timescale 1ns / 1ps

interface kiwdg_in_if;
  logic                            valid;
  logic                            ready;
  logic [kiwdg_pkg::OpcodeW-1:0]   opcode;
  logic [kiwdg_pkg::AddrW-1:0]     reg_addr;
  logic [kiwdg_pkg::DataW-1:0]     write_data;

  modport source (output valid, output opcode, output reg_addr, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input reg_addr, input write_data,
                output ready);
endinterface

interface kiwdg_out_if;
  logic                          valid;
  logic                          ready;
  logic [kiwdg_pkg::ReadW-1:0]   read_data;
  logic                          timeout_pulse;
  logic                          is_running;

  modport source (output valid, output read_data, output timeout_pulse,
                  output is_running, input ready);
  modport sink (input valid, input read_data, input timeout_pulse,
                input is_running, output ready);
endinterface

/* rtl/keyed_independent_watchdog.sv */
// Keyed independent watchdog: key register, prescaler, reload and down counter.
// Depends on kiwdg_pkg and the channel interfaces in kiwdg_if.sv.
//
// Usage:
//   in_i carries one item per handshake: a slow-clock tick, a register write or
//   a register read (opcode, reg_addr, write_data). out_o returns exactly one
//   item per input item: read_data, timeout_pulse and is_running.
//   Writing the unlock key opens the prescaler and reload registers; any other
//   key write closes them. The start key starts the watchdog for good, the
//   refresh key reloads the counter. A running watchdog counts down once every
//   BASE_DIVIDE * 2^prescaler ticks and pulses timeout_pulse on expiry.
// Throughput:
//   one item per cycle while in_i.ready is high; the result is registered on out_o.
//   All state updates and the result are one compare, one decrement and a
//   register update between the input handshake and the result register.
// Stall:
//   a result register plus one skid register; in_i.ready drops only while both
//   hold items, so one more item is taken while a result waits.
// Reset:
//   rst_ni clears the lock, run flag, prescaler and divider, and sets reload and
//   counter to 4095 (cut to COUNTER_BITS); both result slots are emptied.
`timescale 1ns / 1ps

module keyed_independent_watchdog #(
  parameter int unsigned COUNTER_BITS = kiwdg_pkg::CounterBitsDefault,
  parameter int unsigned MAX_EXPONENT = kiwdg_pkg::MaxExponentDefault,
  parameter int unsigned BASE_DIVIDE = kiwdg_pkg::BaseDivideDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kiwdg_in_if.sink    in_i,
  kiwdg_out_if.source out_o
);

  localparam int unsigned ExpW = $clog2(MAX_EXPONENT + 1);
  localparam int unsigned MaxPeriod = BASE_DIVIDE << MAX_EXPONENT;
  localparam int unsigned DivW = $clog2(MaxPeriod + 1);

  // watchdog state
  logic                    unlocked_q, unlocked_d;
  logic                    running_q, running_d;
  logic [ExpW-1:0]         exp_q, exp_d;
  logic [COUNTER_BITS-1:0] reload_q, reload_d;
  logic [COUNTER_BITS-1:0] count_q, count_d;
  logic [DivW-1:0]         div_q, div_d;

  // result slots
  logic                  out_valid_q, out_valid_d;
  kiwdg_pkg::out_item_t  out_item_q, out_item_d;
  logic                  skid_valid_q, skid_valid_d;
  kiwdg_pkg::out_item_t  skid_item_q, skid_item_d;

  logic                  in_fire, out_fire, out_free;
  kiwdg_pkg::out_item_t  result;
  logic [DivW-1:0]       period;
  logic [DivW-1:0]       div_inc;

  assign in_i.ready = !skid_valid_q;
  assign in_fire = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign out_free = out_fire || !out_valid_q;

  assign period = DivW'(BASE_DIVIDE) << exp_q;
  assign div_inc = div_q + DivW'(1);

  // state update and result of one item
  always_comb begin
    unlocked_d = unlocked_q;
    running_d = running_q;
    exp_d = exp_q;
    reload_d = reload_q;
    count_d = count_q;
    div_d = div_q;
    result = '0;
    if (in_fire) begin
      case (in_i.opcode)
        kiwdg_pkg::OP_TICK: begin
          if (running_q) begin
            if (div_inc >= period) begin
              div_d = '0;
              if (count_q <= COUNTER_BITS'(1)) begin
                count_d = reload_q;
                result.timeout_pulse = 1'b1;
              end else begin
                count_d = count_q - COUNTER_BITS'(1);
              end
            end else begin
              div_d = div_inc;
            end
          end
        end
        kiwdg_pkg::OP_WRITE: begin
          case (in_i.reg_addr)
            kiwdg_pkg::ADDR_KEY: begin
              unlocked_d = (in_i.write_data == kiwdg_pkg::KeyUnlock);
              if (in_i.write_data == kiwdg_pkg::KeyStart) begin
                running_d = 1'b1;
                count_d = reload_q;
              end else if (in_i.write_data == kiwdg_pkg::KeyRefresh) begin
                count_d = reload_q;
              end
            end
            kiwdg_pkg::ADDR_PRESCAL: begin
              if (unlocked_q) begin
                if (in_i.write_data > kiwdg_pkg::DataW'(MAX_EXPONENT)) begin
                  exp_d = ExpW'(MAX_EXPONENT);
                end else begin
                  exp_d = in_i.write_data[ExpW-1:0];
                end
              end
            end
            kiwdg_pkg::ADDR_RELOAD: begin
              if (unlocked_q) begin
                reload_d = COUNTER_BITS'(in_i.write_data);
              end
            end
            default: begin
            end
          endcase
        end
        kiwdg_pkg::OP_READ: begin
          case (in_i.reg_addr)
            kiwdg_pkg::ADDR_PRESCAL: result.read_data = kiwdg_pkg::ReadW'(exp_q);
            kiwdg_pkg::ADDR_RELOAD:  result.read_data = kiwdg_pkg::ReadW'(reload_q);
            kiwdg_pkg::ADDR_COUNTER: result.read_data = kiwdg_pkg::ReadW'(count_q);
            default:                 result.read_data = '0;
          endcase
        end
        default: begin
        end
      endcase
    end
    result.is_running = running_d;
  end

  // result register and skid slot
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d = out_item_q;
    skid_valid_d = skid_valid_q;
    skid_item_d = skid_item_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d = 1'b1;
        out_item_d = skid_item_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_fire;
        out_item_d = result;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_item_d = result;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlocked_q <= 1'b0;
      running_q <= 1'b0;
      exp_q <= '0;
      reload_q <= COUNTER_BITS'(kiwdg_pkg::ResetReload);
      count_q <= COUNTER_BITS'(kiwdg_pkg::ResetReload);
      div_q <= '0;
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      unlocked_q <= unlocked_d;
      running_q <= running_d;
      exp_q <= exp_d;
      reload_q <= reload_d;
      count_q <= count_d;
      div_q <= div_d;
      out_valid_q <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    skid_item_q <= skid_item_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.read_data = out_item_q.read_data;
  assign out_o.timeout_pulse = out_item_q.timeout_pulse;
  assign out_o.is_running = out_item_q.is_running;

endmodule
